>>> hdl/chft_pkg.sv
// chft_pkg: shared constants, codes and types for the chained hash filter table
// depends on nothing; used by chft_alu, chained_hash_filter_table_top and the bench
`default_nettype none

package chft_pkg;

    // default sizes, handed to the top level parameters
    localparam int BUCKETS_DEF  = 16;
    localparam int POOL_DEF     = 32;
    localparam int KEY_BITS_DEF = 16;

    // fixed field widths of the request and result ports
    localparam int KEY_W   = 16;
    localparam int LEVEL_W = 8;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // compare flags from the shared subtract unit
    typedef struct packed {
        logic ge;
        logic eq;
    } chft_flags_t;

endpackage

`default_nettype wire

>>> hdl/chft_ram.sv
// chft_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module chft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/chft_alu.sv
// chft_alu: shared subtract and compare unit used for the bucket remainder and key match
// depends on chft_pkg
`default_nettype none

module chft_alu #(
    parameter int W = chft_pkg::KEY_W
) (
    input  wire logic [W-1:0]        a,
    input  wire logic [W-1:0]        b,
    output logic      [W-1:0]        diff,
    output chft_pkg::chft_flags_t    flags
);

    always_comb
    begin
        diff     = a - b;
        flags.ge = (a >= b);
        flags.eq = (a == b);
    end

endmodule

`default_nettype wire

>>> hdl/chained_hash_filter_table_top.sv
// chained_hash_filter_table_top: hash table of component keys to levels, chained pool slots
// depends on chft_pkg, chft_ram, chft_alu
// steps: the remainder (reciprocal multiply, then subtract), the head read, a read and
//   compare per chain slot visited, the action, and (insert of a new key) a scan of up to
//   POOL_ENTRIES slots for a free one, then a link write when the chain had a tail;
//   done is registered and shows in the cycle after the last step
// throughput: one request at a time, set by the shared subtract unit and the single slot ram port
// reset: rst_n clears the sequencer, bucket and slot valid bits; ram contents are left as is
`default_nettype none

module chained_hash_filter_table_top #(
    parameter int BUCKETS      = chft_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chft_pkg::POOL_DEF,
    parameter int KEY_BITS     = chft_pkg::KEY_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [chft_pkg::KEY_W-1:0]    component_key,
    input  wire logic [chft_pkg::LEVEL_W-1:0]  level_value,
    output logic                               done,
    output logic                               status
);

    // key bits actually used, bucket index width
    localparam int SK  = (KEY_BITS < chft_pkg::KEY_W) ? KEY_BITS : chft_pkg::KEY_W;
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW  = (SK > BW) ? SK : BW;
    localparam int PIW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int SW  = $clog2(POOL_ENTRIES + 1);
    localparam int LW  = chft_pkg::LEVEL_W;
    // slot word: {key, level, link, has_link}
    localparam int SWW = SK + LW + PIW + 1;
    // reciprocal of the bucket count, exact quotient for every SK-bit key
    localparam int     LB    = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam int     SH    = SK + LB;
    localparam int     PW    = 2 * SK + 1;
    localparam longint RECIP = ((longint'(1) << SH) + longint'(BUCKETS) - 1) / longint'(BUCKETS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_REM,
        S_HREAD,
        S_HEAD,
        S_SREAD,
        S_SCMP,
        S_ACT,
        S_SCAN,
        S_LINK
    } state_t;

    state_t            state_reg, state_next;
    logic              req_reg, req_next;
    logic [SK-1:0]     key_reg, key_next;
    logic [LW-1:0]     level_reg, level_next;
    logic [SK-1:0]     quot_reg, quot_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [PIW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic              found_reg, found_next;
    logic              hasprev_reg, hasprev_next;
    logic [PIW-1:0]    prev_reg, prev_next;
    logic [SWW-1:0]    prevw_reg, prevw_next;
    logic [SWW-1:0]    hitw_reg, hitw_next;
    logic [PIW-1:0]    idx_reg, idx_next;
    logic [PIW-1:0]    fresh_reg, fresh_next;
    logic [BUCKETS-1:0]      used_reg, used_next;
    logic [POOL_ENTRIES-1:0] valid_reg, valid_next;
    logic              done_reg, done_next;
    logic              status_reg, status_next;

    // shared subtract / compare unit
    logic [AW-1:0]          alu_a, alu_b, alu_diff;
    chft_pkg::chft_flags_t  alu_flags;
    logic [PW-1:0]          prod;

    // slot ram port
    logic              slot_we;
    logic [PIW-1:0]    slot_waddr, slot_raddr;
    logic [SWW-1:0]    slot_wdata, slot_rdata;

    // head ram port
    logic              head_we;
    logic [PIW-1:0]    head_wdata, head_rdata;

    // fields of the slot word just read, and the range check of the current slot
    logic [SK-1:0]     rd_key;
    logic [PIW-1:0]    rd_link;
    logic              rd_has;
    logic              cur_ok;

    assign rd_key  = slot_rdata[SWW-1 -: SK];
    assign rd_link = slot_rdata[PIW:1];
    assign rd_has  = slot_rdata[0];
    assign cur_ok  = ({1'b0, cur_reg} < (PIW + 1)'(POOL_ENTRIES));

    // key times the bucket reciprocal; the quotient sits from bit SH upward
    assign prod = PW'(key_reg) * PW'(RECIP);

    chft_alu #(
        .W (AW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    chft_ram #(
        .WIDTH (SWW),
        .DEPTH (POOL_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    chft_ram #(
        .WIDTH (PIW),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (rem_reg),
        .wdata (head_wdata),
        .raddr (rem_reg),
        .rdata (head_rdata)
    );

    // operand selection for the shared unit
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        if (state_reg == S_REM)
        begin
            alu_a = AW'(key_reg);
            alu_b = AW'(32'(quot_reg) * 32'(BUCKETS));
        end
        else if (state_reg == S_SCMP)
        begin
            alu_a = AW'(key_reg);
            alu_b = AW'(rd_key);
        end
    end

    // sequencer next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        level_next   = level_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        found_next   = found_reg;
        hasprev_next = hasprev_reg;
        prev_next    = prev_reg;
        prevw_next   = prevw_reg;
        hitw_next    = hitw_reg;
        idx_next     = idx_reg;
        fresh_next   = fresh_reg;
        used_next    = used_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        status_next  = chft_pkg::STATUS_OK;
        slot_we      = 1'b0;
        slot_waddr   = cur_reg;
        slot_wdata   = '0;
        slot_raddr   = cur_reg;
        head_we      = 1'b0;
        head_wdata   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req_type;
                    key_next     = component_key[SK-1:0];
                    level_next   = level_value;
                    found_next   = 1'b0;
                    hasprev_next = 1'b0;
                    state_next   = S_MOD;
                end
            end

            // bucket quotient by reciprocal multiply
            S_MOD:
            begin
                quot_next  = SK'(prod >> SH);
                state_next = S_REM;
            end

            // remainder = key - quotient * buckets in the shared unit
            S_REM:
            begin
                rem_next   = alu_diff[BW-1:0];
                state_next = S_HREAD;
            end

            // head ram read in flight
            S_HREAD:
            begin
                state_next = S_HEAD;
            end

            S_HEAD:
            begin
                if (!used_reg[rem_reg])
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    cur_next   = head_rdata;
                    steps_next = '0;
                    state_next = S_SREAD;
                end
            end

            // a free or out-of-range slot ends the chain
            S_SREAD:
            begin
                if (cur_ok && valid_reg[cur_reg])
                begin
                    state_next = S_SCMP;
                end
                else
                begin
                    state_next = S_ACT;
                end
            end

            S_SCMP:
            begin
                if (alu_flags.eq)
                begin
                    found_next = 1'b1;
                    hitw_next  = slot_rdata;
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next    = cur_reg;
                    hasprev_next = 1'b1;
                    prevw_next   = slot_rdata;
                    steps_next   = steps_reg + SW'(1);
                    if (!rd_has || ((steps_reg + SW'(1)) == SW'(POOL_ENTRIES)))
                    begin
                        state_next = S_ACT;
                    end
                    else
                    begin
                        cur_next   = rd_link;
                        state_next = S_SREAD;
                    end
                end
            end

            S_ACT:
            begin
                if (req_reg == chft_pkg::REQ_INSERT)
                begin
                    if (found_reg)
                    begin
                        // level update in place
                        slot_we    = 1'b1;
                        slot_waddr = cur_reg;
                        slot_wdata = {key_reg, level_reg, hitw_reg[PIW:0]};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        // unlink the hit, joining the rest of the chain
                        if (hasprev_reg)
                        begin
                            slot_we    = 1'b1;
                            slot_waddr = prev_reg;
                            slot_wdata = {prevw_reg[SWW-1:PIW+1], hitw_reg[PIW:0]};
                        end
                        else if (hitw_reg[0])
                        begin
                            head_we    = 1'b1;
                            head_wdata = hitw_reg[PIW:1];
                        end
                        else
                        begin
                            used_next[rem_reg] = 1'b0;
                        end
                        valid_next[cur_reg] = 1'b0;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // lowest free slot, one per cycle
            S_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    slot_we             = 1'b1;
                    slot_waddr          = idx_reg;
                    slot_wdata          = {key_reg, level_reg, {PIW{1'b0}}, 1'b0};
                    valid_next[idx_reg] = 1'b1;
                    fresh_next          = idx_reg;
                    if (hasprev_reg)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        head_we            = 1'b1;
                        head_wdata         = idx_reg;
                        used_next[rem_reg] = 1'b1;
                        done_next          = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else if (idx_reg == PIW'(POOL_ENTRIES - 1))
                begin
                    status_next = chft_pkg::STATUS_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + PIW'(1);
                end
            end

            // append the new slot after the old tail
            S_LINK:
            begin
                slot_we    = 1'b1;
                slot_waddr = prev_reg;
                slot_wdata = {prevw_reg[SWW-1:PIW+1], fresh_reg, 1'b1};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= chft_pkg::STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        level_reg   <= level_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        found_reg   <= found_next;
        hasprev_reg <= hasprev_next;
        prev_reg    <= prev_next;
        prevw_reg   <= prevw_next;
        hitw_reg    <= hitw_next;
        idx_reg     <= idx_next;
        fresh_reg   <= fresh_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    // a transfer starts the sequencer
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // every finished request gives exactly one result strobe
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer returned to idle without a result");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // full status only on an insert result
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        status |-> (done && (req_reg == chft_pkg::REQ_INSERT)))
        else $error("full status outside an insert result");

    // the reciprocal quotient never overshoots the key
    a_rem_ge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> alu_flags.ge)
        else $error("bucket quotient too large");
`endif

endmodule

`default_nettype wire

>>> verif/tb_chained_hash_filter_table_top.sv
// tb_chained_hash_filter_table_top: self-checking bench for the chained hash filter table
// depends on chft_pkg and chained_hash_filter_table_top; a directed table, then random
// traffic; each status checked against the row's known value or a behavioral table copy
`timescale 1ns / 100ps

module tb_chained_hash_filter_table_top;

    localparam int KEY_W    = chft_pkg::KEY_W;
    localparam int LEVEL_W  = chft_pkg::LEVEL_W;
    localparam int NBKT     = chft_pkg::BUCKETS_DEF;
    localparam int NSLOT    = chft_pkg::POOL_DEF;
    localparam int NDIR     = 23;
    localparam int NKEYS    = 48;
    localparam int IDLE_MAX = 5000;

    // one directed row; reps > 1 repeats the transfer with the key stepped by one
    // bucket stride, so every copy lands in the same chain
    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [LEVEL_W-1:0] lvl;
        logic [5:0]         reps;
        logic               known;
        logic               want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               req_type = chft_pkg::REQ_INSERT;
    logic [KEY_W-1:0]   component_key = '0;
    logic [LEVEL_W-1:0] level_value = '0;
    wire                busy;
    wire                done;
    wire                status;

    chained_hash_filter_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .component_key (component_key),
        .level_value   (level_value),
        .done          (done),
        .status        (status)
    );

    // behavioral copy of the table
    logic             bkt_used      [NBKT];
    int               bkt_head      [NBKT];
    logic             slot_valid    [NSLOT];
    logic [KEY_W-1:0] slot_key      [NSLOT];
    int               slot_link     [NSLOT];
    logic             slot_has_link [NSLOT];

    logic      status_due [$];
    stim_row_t dir_rows [NDIR];
    int        errors = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    // applies one request to the table copy and returns the status it must give;
    // the level itself never affects the status
    function automatic logic table_update(input logic op, input logic [KEY_W-1:0] key);
        int   bkt, cur, hit, prv, fresh;
        logic found, has_prv, st;
        bkt = key % NBKT;
        found = 1'b0;
        has_prv = 1'b0;
        hit = 0;
        prv = 0;
        st = chft_pkg::STATUS_OK;
        // walk the chain
        if (bkt_used[bkt]) begin
            cur = bkt_head[bkt];
            for (int s = 0; s < NSLOT; s++) begin
                if (cur >= NSLOT || !slot_valid[cur])
                    break;
                if (slot_key[cur] == key) begin
                    hit = cur;
                    found = 1'b1;
                    break;
                end
                prv = cur;
                has_prv = 1'b1;
                if (!slot_has_link[cur])
                    break;
                cur = slot_link[cur];
            end
        end
        if (op == chft_pkg::REQ_INSERT) begin
            if (!found) begin
                fresh = NSLOT;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (!slot_valid[i])
                        fresh = i;
                if (fresh >= NSLOT) begin
                    st = chft_pkg::STATUS_FULL;
                end
                else begin
                    slot_valid[fresh] = 1'b1;
                    slot_key[fresh] = key;
                    slot_has_link[fresh] = 1'b0;
                    slot_link[fresh] = 0;
                    if (has_prv) begin
                        slot_link[prv] = fresh;
                        slot_has_link[prv] = 1'b1;
                    end
                    else begin
                        bkt_head[bkt] = fresh;
                        bkt_used[bkt] = 1'b1;
                    end
                end
            end
        end
        else if (found) begin
            // unlink and join the rest of the chain to the predecessor or the head
            if (has_prv) begin
                slot_has_link[prv] = slot_has_link[hit];
                slot_link[prv] = slot_link[hit];
            end
            else if (slot_has_link[hit]) begin
                bkt_head[bkt] = slot_link[hit];
            end
            else begin
                bkt_used[bkt] = 1'b0;
            end
            slot_valid[hit] = 1'b0;
            slot_has_link[hit] = 1'b0;
        end
        return st;
    endfunction

    function automatic stim_row_t mk_row(input logic op, input logic [KEY_W-1:0] key,
                                         input logic [LEVEL_W-1:0] lvl, input int reps,
                                         input logic known, input logic want);
        stim_row_t r;
        r.op = op;
        r.key = key;
        r.lvl = lvl;
        r.reps = reps[5:0];
        r.known = known;
        r.want = want;
        return r;
    endfunction

    // one transfer; the sender runs in bursts and drops start only inside a gap
    task automatic send_req(input logic op, input logic [KEY_W-1:0] key,
                            input logic [LEVEL_W-1:0] lvl, input logic known,
                            input logic want);
        logic st;
        int   gap;
        start <= 1'b1;
        req_type <= op;
        component_key <= key;
        level_value <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        st = table_update(op, key);
        status_due.push_back(known ? want : st);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // result checker and stall watchdog
    always @(posedge clk) begin
        logic want;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && done) begin
            if (status_due.size() == 0) begin
                $display("%0t: unexpected done, expected none, actual status %0b",
                         $time, status);
                errors++;
            end
            else begin
                want = status_due.pop_front();
                if (status !== want) begin
                    $display("%0t: status mismatch, expected %0b, actual %0b",
                             $time, want, status);
                    errors++;
                end
            end
        end
        if (idle_cycles >= IDLE_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int               ins_pct;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] key_set [NKEYS];

        for (int i = 0; i < NBKT; i++) begin
            bkt_used[i] = 1'b0;
            bkt_head[i] = 0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_link[i] = 0;
            slot_has_link[i] = 1'b0;
        end

        // directed: edges of the key and level, chain repairs, pool full
        dir_rows[0]  = mk_row(chft_pkg::REQ_DELETE, 16'h0000, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[1]  = mk_row(chft_pkg::REQ_INSERT, 16'h0000, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[2]  = mk_row(chft_pkg::REQ_INSERT, 16'hFFFF, 8'hFF, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[3]  = mk_row(chft_pkg::REQ_INSERT, 16'hFFFF, 8'h5A, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[4]  = mk_row(chft_pkg::REQ_INSERT, 16'h0010, 8'hA5, 1, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[5]  = mk_row(chft_pkg::REQ_INSERT, 16'h0020, 8'h3C, 1, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[6]  = mk_row(chft_pkg::REQ_DELETE, 16'h0010, 8'hFF, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[7]  = mk_row(chft_pkg::REQ_INSERT, 16'h0010, 8'h11, 1, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[8]  = mk_row(chft_pkg::REQ_DELETE, 16'h0000, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[9]  = mk_row(chft_pkg::REQ_DELETE, 16'hFFFF, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[10] = mk_row(chft_pkg::REQ_DELETE, 16'hFFFF, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        // two slots in use, so thirty more fill the pool with one long chain
        dir_rows[11] = mk_row(chft_pkg::REQ_INSERT, 16'h0005, 8'h40, 30, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[12] = mk_row(chft_pkg::REQ_INSERT, 16'h1235, 8'h77, 1, 1'b1,
                              chft_pkg::STATUS_FULL);
        dir_rows[13] = mk_row(chft_pkg::REQ_INSERT, 16'hABC0, 8'h88, 1, 1'b1,
                              chft_pkg::STATUS_FULL);
        // full insert into an empty bucket
        dir_rows[14] = mk_row(chft_pkg::REQ_INSERT, 16'h0003, 8'h99, 1, 1'b1,
                              chft_pkg::STATUS_FULL);
        // update of the chain tail still works while full
        dir_rows[15] = mk_row(chft_pkg::REQ_INSERT, 16'h01D5, 8'hFE, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[16] = mk_row(chft_pkg::REQ_DELETE, 16'h00A5, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[17] = mk_row(chft_pkg::REQ_INSERT, 16'h0003, 8'hC3, 1, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[18] = mk_row(chft_pkg::REQ_DELETE, 16'h0005, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[19] = mk_row(chft_pkg::REQ_DELETE, 16'h01D5, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[20] = mk_row(chft_pkg::REQ_INSERT, 16'h1235, 8'h01, 1, 1'b0,
                              chft_pkg::STATUS_OK);
        dir_rows[21] = mk_row(chft_pkg::REQ_DELETE, 16'h0003, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);
        dir_rows[22] = mk_row(chft_pkg::REQ_DELETE, 16'h0020, 8'h00, 1, 1'b1,
                              chft_pkg::STATUS_OK);

        for (int i = 0; i < NKEYS; i++)
            key_set[i] = KEY_W'($urandom_range(0, 65535));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NDIR; r++)
            for (int n = 0; n < dir_rows[r].reps; n++)
                send_req(dir_rows[r].op, dir_rows[r].key + KEY_W'(n * NBKT),
                         dir_rows[r].lvl + LEVEL_W'(n), dir_rows[r].known,
                         dir_rows[r].want);

        // random: a working set a bit larger than the pool keeps chains long and
        // hits frequent; phases of insert-heavy traffic push the pool to full
        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(0, 2))
                0: ins_pct = 85;
                1: ins_pct = 50;
                default: ins_pct = 20;
            endcase
            for (int i = 0; i < 100; i++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? chft_pkg::REQ_INSERT
                                                       : chft_pkg::REQ_DELETE;
                if ($urandom_range(0, 7) == 0)
                    key = KEY_W'($urandom_range(0, 65535));
                else
                    key = key_set[$urandom_range(0, NKEYS - 1)];
                send_req(op, key, LEVEL_W'($urandom_range(0, 255)), 1'b0,
                         chft_pkg::STATUS_OK);
            end
        end

        start <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
